### sv/fifo_queue_with_search_assert.svh
// Assertion macros for the queue checker
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// property checked every clock edge outside reset
`define FQWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on the following edge
`define FQWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/fqws_pkg.sv
// Shared types and codes for the search queue
`default_nettype none
package fqws_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [4:0]               position;
      logic signed [DATA_W-1:0] popped_value;
      logic [4:0]               occupancy;
   } rsp_type;

endpackage
`default_nettype wire

### sv/fifo_queue_with_search.sv
// Top level of the bounded queue with search by position
//
// A beat is taken on start while busy is low. Push, rejected push, pops and
// searches on an empty queue and unused action codes give their result in
// the cycle after the beat is taken and keep busy low, so such beats can
// follow every cycle. A pop holds busy high in the pop state and gives its
// result from the output register after that state. A search reads one
// stored entry per cycle through the single read port of the entry RAM,
// starting at the head, and stops at the first match or once every stored
// entry has been compared. Each result sits on rsp_item for exactly one
// cycle with rsp_strobe high; the receiver cannot stall it.
`default_nettype none
module fifo_queue_with_search #(
   parameter int DEPTH = fqws_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire fqws_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output fqws_pkg::rsp_type      rsp_item
);

   localparam int PW = $clog2(DEPTH);

   logic                        wr_en;
   logic [PW-1:0]               wr_addr;
   logic [fqws_pkg::DATA_W-1:0] wr_data;
   logic [PW-1:0]               rd_addr;
   logic [fqws_pkg::DATA_W-1:0] rd_data;

   fqws_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   fqws_ram #(.WIDTH(fqws_pkg::DATA_W), .DEPTH(DEPTH)) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

### sv/fqws_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module fqws_ram #(
   parameter int WIDTH = fqws_pkg::DATA_W,
   parameter int DEPTH = fqws_pkg::DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/fqws_ctrl.sv
// Queue pointers, action sequencer and search walk
`default_nettype none
module fqws_ctrl #(
   parameter int DEPTH = fqws_pkg::DEPTH_DEFAULT,
   localparam int PW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire fqws_pkg::req_type              req_item,
   output logic                                rsp_strobe,
   output fqws_pkg::rsp_type                   rsp_item,
   output logic                                wr_en,
   output logic [PW-1:0]                       wr_addr,
   output logic [fqws_pkg::DATA_W-1:0]         wr_data,
   output logic [PW-1:0]                       rd_addr,
   input  wire logic [fqws_pkg::DATA_W-1:0]    rd_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_SEARCH} state_type;

   state_type                         state_ff, state_in;
   logic [PW-1:0]                     head_ff, head_in;
   logic [PW-1:0]                     tail_ff, tail_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [PW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     k_ff, k_in;
   logic [fqws_pkg::DATA_W-1:0]       value_ff, value_in;
   logic                              strobe_ff, strobe_in;
   fqws_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                              full, empty;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      value_in  = value_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      rd_addr   = (state_ff == ST_IDLE) ? head_ff : idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in           = 1'b1;
               rsp_in.status       = fqws_pkg::STAT_OK;
               rsp_in.position     = '0;
               rsp_in.popped_value = '0;
               rsp_in.occupancy    = 5'(count_ff);
               unique case (req_item.action)
                  fqws_pkg::ACT_PUSH: begin
                     if (full) begin
                        rsp_in.status = fqws_pkg::STAT_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        tail_in          = ring_next(tail_ff);
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = 5'(count_ff + 1'b1);
                     end
                  end
                  fqws_pkg::ACT_POP: begin
                     if (empty) begin
                        rsp_in.status = fqws_pkg::STAT_EMPTY;
                     end else begin
                        strobe_in = 1'b0;
                        state_in  = ST_POP;
                     end
                  end
                  fqws_pkg::ACT_SEARCH: begin
                     if (empty) begin
                        rsp_in.status = fqws_pkg::STAT_EMPTY;
                     end else begin
                        strobe_in = 1'b0;
                        state_in  = ST_SEARCH;
                        idx_in    = ring_next(head_ff);
                        k_in      = '0;
                        value_in  = req_item.value;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            strobe_in           = 1'b1;
            rsp_in.status       = fqws_pkg::STAT_OK;
            rsp_in.position     = '0;
            rsp_in.popped_value = rd_data;
            rsp_in.occupancy    = 5'(count_ff - 1'b1);
            head_in             = ring_next(head_ff);
            count_in            = count_ff - 1'b1;
            state_in            = ST_IDLE;
         end
         ST_SEARCH: begin
            if (rd_data == value_ff) begin
               strobe_in           = 1'b1;
               rsp_in.status       = fqws_pkg::STAT_OK;
               rsp_in.position     = 5'(k_ff + 1'b1);
               rsp_in.popped_value = '0;
               rsp_in.occupancy    = 5'(count_ff);
               state_in            = ST_IDLE;
            end else if ((k_ff + 1'b1) == count_ff) begin
               strobe_in           = 1'b1;
               rsp_in.status       = fqws_pkg::STAT_NOTFOUND;
               rsp_in.position     = '0;
               rsp_in.popped_value = '0;
               rsp_in.occupancy    = 5'(count_ff);
               state_in            = ST_IDLE;
            end else begin
               idx_in = ring_next(idx_ff);
               k_in   = k_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      idx_ff   <= idx_in;
      k_ff     <= k_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
   assign wr_addr    = tail_ff;
   assign wr_data    = req_item.value;

endmodule
`default_nettype wire

### sv/fqws_checker.sv
// Port-level checks for the search queue, bound to the top level
`default_nettype none
`include "fifo_queue_with_search_assert.svh"
module fqws_checker #(
   parameter int DEPTH = fqws_pkg::DEPTH_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire fqws_pkg::req_type req_item,
   input wire logic              rsp_strobe,
   input wire fqws_pkg::rsp_type rsp_item
);

   `FQWS_ASSERT_NEXT(a_push_next, start && !busy && req_item.action == fqws_pkg::ACT_PUSH, rsp_strobe, "push beat gave no result next cycle")
   `FQWS_ASSERT(a_full_occ, !rsp_strobe || rsp_item.status != fqws_pkg::STAT_FULL || rsp_item.occupancy == 5'(DEPTH), "full status with queue not full")
   `FQWS_ASSERT(a_empty_res, !rsp_strobe || rsp_item.status != fqws_pkg::STAT_EMPTY || (rsp_item.occupancy == 5'd0 && rsp_item.popped_value == '0), "empty status with data or occupancy")
   `FQWS_ASSERT(a_busy_end, !($fell(busy) && !$past(reset)) || rsp_strobe, "busy ended without a result")

endmodule

bind fifo_queue_with_search fqws_checker #(.DEPTH(DEPTH)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
`default_nettype wire
